@@ rtl/dfrx_pkg.sv @@
// Shared constants, codes and control types for the delimited frame receiver.
package dfrx_pkg;

  localparam int MAX_DATA_DEF  = 12;
  localparam int BODY_OVERHEAD = 3;
  localparam int SUM_W         = 7;
  localparam int BYTE_W        = 8;
  localparam int CNT_OUT_W     = 4;
  localparam int STAT_W        = 2;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'd1;

  localparam logic [STAT_W-1:0] FS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] FS_BAD_SUM = 2'd1;
  localparam logic [STAT_W-1:0] FS_SHORT   = 2'd2;
  localparam logic [STAT_W-1:0] FS_LONG    = 2'd3;

  typedef struct packed {
    logic take;
    logic rd;
    logic load;
    logic adv;
  } dfrx_cmd_t;

  typedef struct packed {
    logic close;
    logic multi;
    logic last;
    logic out_free;
  } dfrx_sts_t;

endpackage

@@ rtl/dfrx_ctrl.sv @@
// Controller state machine: input acceptance and result sequencing.
module dfrx_ctrl import dfrx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dfrx_sts_t sts_i,
  output dfrx_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.close) begin
          state_d = sts_i.multi ? ST_READ : ST_LOAD;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/dfrx_dp.sv @@
// Datapath: marker registers, body store, checksum, judgment and result register.
module dfrx_dp import dfrx_pkg::*; #(
  parameter int MAX_DATA = MAX_DATA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  dfrx_cmd_t            cmd_i,
  output dfrx_sts_t            sts_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [BYTE_W-1:0]    frame_address_o,
  output logic [BYTE_W-1:0]    frame_command_o,
  output logic [CNT_OUT_W-1:0] data_count_o,
  output logic [CNT_OUT_W-1:0] data_index_o,
  output logic [BYTE_W-1:0]    data_value_o,
  output logic [STAT_W-1:0]    frame_status_o,
  output logic                 last_of_frame_o
);

  localparam int STORE_DEPTH = MAX_DATA + BODY_OVERHEAD;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic [BYTE_W-1:0] start_q, end_q;
  logic              in_frame_q;
  logic [CNT_W-1:0]  count_q;
  logic              too_long_q;
  logic [BYTE_W-1:0] addr_q, cmd_q, last_q;
  logic [SUM_W-1:0]  sum_all_q, sum_prev_q;
  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic [CNT_W-1:0]  idx_q, n_q;
  logic [STAT_W-1:0] status_q;
  logic              single_q;

  logic [STAT_W-1:0] status_d;
  logic [CNT_W-1:0]  n_d;
  logic              is_close, is_store, ok_d, multi_d;
  logic [CNT_W-1:0]  rd_sum;
  logic [CNT_W+CNT_OUT_W-1:0] n_ext, idx_ext;

  assign is_close = in_frame_q && (rx_byte_i == end_q);
  assign is_store = cmd_i.take && in_frame_q && !is_close &&
                    (count_q < CNT_W'(STORE_DEPTH));
  assign n_d      = count_q - CNT_W'(BODY_OVERHEAD);

  always_comb begin
    if (too_long_q) begin
      status_d = FS_LONG;
    end else if (count_q < CNT_W'(BODY_OVERHEAD)) begin
      status_d = FS_SHORT;
    end else if ({1'b0, sum_prev_q} != last_q) begin
      status_d = FS_BAD_SUM;
    end else begin
      status_d = FS_OK;
    end
  end

  assign ok_d    = (status_d == FS_OK);
  assign multi_d = ok_d && (n_d != '0);

  assign sts_o.close    = is_close;
  assign sts_o.multi    = multi_d;
  assign sts_o.last     = single_q || (idx_q == n_q - CNT_W'(1));
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      end_q      <= '0;
      in_frame_q <= 1'b0;
      count_q    <= '0;
      too_long_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == REG_START_MARKER) begin
        start_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == REG_END_MARKER) begin
        end_q <= cfg_data_i;
      end
      if (cmd_i.take) begin
        if (!in_frame_q) begin
          if (rx_byte_i == start_q) begin
            in_frame_q <= 1'b1;
            count_q    <= '0;
            too_long_q <= 1'b0;
          end
        end else if (is_close) begin
          in_frame_q <= 1'b0;
        end else if (count_q < CNT_W'(STORE_DEPTH)) begin
          count_q <= count_q + CNT_W'(1);
        end else begin
          too_long_q <= 1'b1;
        end
      end
      if (cmd_i.load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign rd_sum = idx_q + CNT_W'(2);

  always_ff @(posedge clk_i) begin
    if (is_store) begin
      mem[count_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_sum[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !in_frame_q && rx_byte_i == start_q) begin
      sum_all_q  <= '0;
      sum_prev_q <= '0;
    end
    if (is_store) begin
      sum_prev_q <= sum_all_q;
      sum_all_q  <= sum_all_q + rx_byte_i[SUM_W-1:0];
      last_q     <= rx_byte_i;
      if (count_q == CNT_W'(0)) begin
        addr_q <= rx_byte_i;
      end
      if (count_q == CNT_W'(1)) begin
        cmd_q <= rx_byte_i;
      end
    end
    if (cmd_i.take && is_close) begin
      status_q <= status_d;
      n_q      <= n_d;
      single_q <= !multi_d;
      idx_q    <= '0;
    end else if (cmd_i.adv) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  assign n_ext   = {{CNT_OUT_W{1'b0}}, n_q};
  assign idx_ext = {{CNT_OUT_W{1'b0}}, idx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_address_o <= (count_q >= CNT_W'(1)) ? addr_q : '0;
      frame_command_o <= (count_q >= CNT_W'(2)) ? cmd_q : '0;
      data_count_o    <= single_q ? '0 : n_ext[CNT_OUT_W-1:0];
      data_index_o    <= single_q ? '0 : idx_ext[CNT_OUT_W-1:0];
      data_value_o    <= single_q ? '0 : rd_data_q;
      frame_status_o  <= status_q;
      last_of_frame_o <= sts_o.last;
    end
  end

endmodule

@@ rtl/delimited_frame_receiver_sum_check.sv @@
// Top level of the delimited frame receiver with 7-bit additive checksum.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_stall    rx_byte
//   out      out        out_valid/out_stall  frame fields, status, last flag
//
// A byte that hunts or stores is accepted without holding the input. An end byte
// is judged in its accept cycle, then holds the input while each data word passes
// a store read and then a result load, or a result load alone for a single result
// word, as the body store has a single read port for the data words. Reset clears
// markers and framing state; the store is not cleared. Output stalls hold the
// result register and stretch the load.
module delimited_frame_receiver_sum_check import dfrx_pkg::*; #(
  parameter int MAX_DATA = MAX_DATA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    frame_address_o,
  output logic [BYTE_W-1:0]    frame_command_o,
  output logic [CNT_OUT_W-1:0] data_count_o,
  output logic [CNT_OUT_W-1:0] data_index_o,
  output logic [BYTE_W-1:0]    data_value_o,
  output logic [STAT_W-1:0]    frame_status_o,
  output logic                 last_of_frame_o
);

  dfrx_cmd_t cmd;
  dfrx_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dfrx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfrx_dp #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .frame_address_o (frame_address_o),
    .frame_command_o (frame_command_o),
    .data_count_o    (data_count_o),
    .data_index_o    (data_index_o),
    .data_value_o    (data_value_o),
    .frame_status_o  (frame_status_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

@@ sim/frame_check_pkg.sv @@
// Expected-word predictor and result checker for the delimited frame receiver.
package frame_check_pkg;
  import dfrx_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct packed {
    logic [BYTE_W-1:0]    addr;
    logic [BYTE_W-1:0]    cmd;
    logic [CNT_OUT_W-1:0] count;
    logic [CNT_OUT_W-1:0] index;
    logic [BYTE_W-1:0]    value;
    logic [STAT_W-1:0]    status;
    logic                 last;
  } frame_word_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0] start_m = '0;
    logic [BYTE_W-1:0] end_m = '0;
    bit                in_frame = 1'b0;
    int                body_len = 0;
    bit                overflow = 1'b0;
    logic [BYTE_W-1:0] body [MAX_DATA_DEF+BODY_OVERHEAD];
    frame_word_t       pending[$];
    int unsigned       errors = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
      if (idx == REG_START_MARKER) begin
        start_m = v;
      end else if (idx == REG_END_MARKER) begin
        end_m = v;
      end
    endfunction

    function void push_word(int count, int index, logic [BYTE_W-1:0] value,
                            logic [STAT_W-1:0] status, logic last);
      frame_word_t w;
      w.addr   = (body_len >= 1) ? body[0] : '0;
      w.cmd    = (body_len >= 2) ? body[1] : '0;
      w.count  = CNT_OUT_W'(count);
      w.index  = CNT_OUT_W'(index);
      w.value  = value;
      w.status = status;
      w.last   = last;
      pending.push_back(w);
    endfunction

    function void push_single(logic [STAT_W-1:0] status);
      push_word(0, 0, '0, status, 1'b1);
    endfunction

    function void judge_frame();
      int                 n;
      logic [SUM_W-1:0]   acc;
      if (overflow) begin
        push_single(FS_LONG);
      end else if (body_len < BODY_OVERHEAD) begin
        push_single(FS_SHORT);
      end else begin
        n = body_len - BODY_OVERHEAD;
        acc = '0;
        for (int i = 0; i < n + 2; i++) acc += body[i][SUM_W-1:0];
        if ({1'b0, acc} != body[body_len-1]) begin
          push_single(FS_BAD_SUM);
        end else if (n == 0) begin
          push_single(FS_OK);
        end else begin
          for (int i = 0; i < n; i++) push_word(n, i, body[2+i], FS_OK, i == n - 1);
        end
      end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      if (!in_frame) begin
        if (b == start_m) begin
          in_frame = 1'b1;
          body_len = 0;
          overflow = 1'b0;
        end
      end else if (b == end_m) begin
        judge_frame();
        in_frame = 1'b0;
      end else if (body_len < MAX_DATA_DEF + BODY_OVERHEAD) begin
        body[body_len] = b;
        body_len++;
      end else begin
        overflow = 1'b1;
      end
    endfunction

    function void check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] cmd,
                             logic [CNT_OUT_W-1:0] count, logic [CNT_OUT_W-1:0] index,
                             logic [BYTE_W-1:0] value, logic [STAT_W-1:0] status,
                             logic last);
      frame_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected frame word: address %0h status %0h", addr, status);
        errors++;
        return;
      end
      w = pending.pop_front();
      check_field("frame_address", w.addr, addr);
      check_field("frame_command", w.cmd, cmd);
      check_field("data_count", BYTE_W'(w.count), BYTE_W'(count));
      check_field("data_index", BYTE_W'(w.index), BYTE_W'(index));
      check_field("data_value", w.value, value);
      check_field("frame_status", BYTE_W'(w.status), BYTE_W'(status));
      check_field("last_of_frame", BYTE_W'(w.last), BYTE_W'(last));
    endfunction
  endclass

endpackage

@@ sim/tb_top.sv @@
// Top-level testbench: drives frames through the receiver and checks every word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dfrx_pkg::*;
  import frame_check_pkg::*;

  typedef enum {FK_GOOD, FK_BAD_SUM, FK_SHORT, FK_LONG, FK_NOISE} frame_kind_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PRESSURE_HOLD  = 400;
  localparam int PHASE_BYTES    = 32;
  localparam int NUM_PHASES     = 5;

  localparam logic [7:0] START_TAB [NUM_PHASES] = '{8'h00, 8'hFF, 8'hA5, 8'h55, 8'h3C};
  localparam logic [7:0] END_TAB   [NUM_PHASES] = '{8'hFF, 8'h00, 8'hA5, 8'hAA, 8'hC3};
  localparam int         IDLE_TAB  [NUM_PHASES] = '{0, 46, 0, 27, 0};
  localparam int         STALL_TAB [NUM_PHASES] = '{0, 0, 46, 27, 0};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    frame_address;
  logic [BYTE_W-1:0]    frame_command;
  logic [CNT_OUT_W-1:0] data_count;
  logic [CNT_OUT_W-1:0] data_index;
  logic [BYTE_W-1:0]    data_value;
  logic [STAT_W-1:0]    frame_status;
  logic                 last_of_frame;

  frame_scoreboard sb = new;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit pressure_on = 1'b0;
  int hold_cnt = 0;
  int stuck_cycles = 0;
  int bytes_sent = 0;

  delimited_frame_receiver_sum_check uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .frame_address_o (frame_address),
    .frame_command_o (frame_command),
    .data_count_o    (data_count),
    .data_index_o    (data_index),
    .data_value_o    (data_value),
    .frame_status_o  (frame_status),
    .last_of_frame_o (last_of_frame)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (pressure_on && hold_cnt < PRESSURE_HOLD) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(rx_byte);
      if (out_valid && !out_stall) begin
        sb.check_word(frame_address, frame_command, data_count, data_index,
                      data_value, frame_status, last_of_frame);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] sum7(byte_q_t q);
    logic [SUM_W-1:0] acc;
    acc = '0;
    foreach (q[i]) acc += q[i][SUM_W-1:0];
    return {1'b0, acc};
  endfunction

  function automatic byte_q_t seal(byte_q_t q);
    q.push_back(sum7(q));
    return q;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = ($urandom_range(15) == 0) ? sb.start_m : 8'($urandom);
    if (b == sb.end_m) b = ~b;
    return b;
  endfunction

  function automatic byte_q_t make_body(frame_kind_t kind, int n);
    byte_q_t    q;
    logic [7:0] chk;
    case (kind)
      FK_GOOD, FK_BAD_SUM: begin
        do begin
          q.delete();
          for (int i = 0; i < n + 2; i++) q.push_back(body_byte());
          chk = sum7(q);
        end while (chk == sb.end_m);
        if (kind == FK_BAD_SUM) begin
          chk = ($urandom_range(1) == 1) ? (chk | 8'h80) : 8'($urandom);
          while (chk == sum7(q) || chk == sb.end_m) chk = 8'($urandom);
        end
        q.push_back(chk);
      end
      FK_SHORT: begin
        repeat ($urandom_range(2)) q.push_back(body_byte());
      end
      FK_LONG: begin
        repeat ($urandom_range(20, 16)) q.push_back(body_byte());
      end
      default: begin
      end
    endcase
    return q;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t body, input int noise);
    logic [7:0] b;
    repeat (noise) begin
      b = 8'($urandom);
      if (b == sb.start_m) b = ~b;
      send_byte(b);
    end
    send_byte(sb.start_m);
    foreach (body[i]) send_byte(body[i]);
    send_byte(sb.end_m);
  endtask

  task automatic send_random_frame();
    int          roll;
    int          n;
    frame_kind_t kind;
    roll = $urandom_range(99);
    kind = (roll < 60) ? FK_GOOD : (roll < 72) ? FK_BAD_SUM : (roll < 80) ? FK_SHORT :
           (roll < 88) ? FK_LONG : FK_NOISE;
    n = ($urandom_range(3) == 0) ? MAX_DATA_DEF : $urandom_range(MAX_DATA_DEF);
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(12, 1)) send_byte(8'($urandom));
    end else begin
      send_frame(make_body(kind, n), $urandom_range(2));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_data <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_END_MARKER;
    cfg_data <= e;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_register(REG_START_MARKER, s);
    sb.set_register(REG_END_MARKER, e);
  endtask

  initial begin
    byte_q_t q;
    int      target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_markers(8'h7E, 8'h7D);
    q = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7E, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h55,
          8'hAA, 8'h33, 8'hCC, 8'hFF};
    send_frame(seal(q), 0);
    q = '{8'h12, 8'h34};
    send_frame(seal(q), 1);
    q = '{8'h12, 8'h34, 8'hC6};
    send_frame(q, 0);
    q = '{8'h01, 8'h02, 8'h05, 8'h09};
    send_frame(q, 0);
    q.delete();
    send_frame(q, 0);
    q = '{8'h11};
    send_frame(q, 0);
    q = '{8'h11, 8'h22};
    send_frame(q, 0);
    q = '{8'h00, 8'hFF, 8'h80};
    send_frame(seal(q), 2);
    send_frame(make_body(FK_LONG, 0), 0);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_markers(START_TAB[p], END_TAB[p]);
      send_idle_pct = IDLE_TAB[p];
      stall_pct <= STALL_TAB[p];
      target = bytes_sent + PHASE_BYTES;
      if (p == NUM_PHASES - 1) begin
        pressure_on <= 1'b1;
        send_frame(make_body(FK_GOOD, MAX_DATA_DEF), 0);
        send_frame(make_body(FK_GOOD, MAX_DATA_DEF), 0);
      end
      while (bytes_sent < target) send_random_frame();
      settle();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
